>>> design/dfr_pkg.sv
// Package for the dragonfly next-port router: sizes, register indexes and pipeline types.
package dfr_pkg;

   localparam int GROUP_BITS = 10;
   localparam int PORT_BITS  = 8;

   localparam logic [9:0] GROUP_MASK = 10'((1 << GROUP_BITS) - 1);

   // Divider step counts: destination id by hosts per group, then the
   // remainder by hosts per router and the group index by global links.
   localparam int DIV_A_STEPS = 16;
   localparam int DIV_B_STEPS = 13;

   localparam logic [2:0] CSR_HOSTS_PER_ROUTER  = 3'd0;
   localparam logic [2:0] CSR_ROUTERS_PER_GROUP = 3'd1;
   localparam logic [2:0] CSR_GLOBAL_LINKS      = 3'd2;
   localparam logic [2:0] CSR_GROUP_COUNT       = 3'd3;
   localparam logic [2:0] CSR_OWN_GROUP         = 3'd4;
   localparam logic [2:0] CSR_OWN_ROUTER        = 3'd5;
   localparam logic [2:0] CSR_VALIANT_MODE      = 3'd6;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_VIA = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   typedef enum logic [1:0] {
      MODE_DROP  = 2'd0,
      MODE_GROUP = 2'd1,
      MODE_LOCAL = 2'd2
   } mode_type;

   // First divider: quotient bits shift into num as dividend bits leave it.
   typedef struct packed {
      logic [15:0] num;
      logic [12:0] rem;
      logic [3:0]  vc;
      logic [9:0]  via;
   } a_stage_type;

   // Second pair of dividers, run side by side.
   typedef struct packed {
      mode_type    mode;
      logic [1:0]  status;
      logic [3:0]  vc;
      logic [12:0] rnum;
      logic [5:0]  rrem;
      logic [12:0] hnum;
      logic [5:0]  hrem;
   } b_stage_type;

endpackage

>>> design/dragonfly_next_port_router.sv
// Dragonfly router route computation: output port, virtual channel and status per packet.
// A transaction accepted at a clock edge passes the entry, divider, decision and output
// registers; its result is then on the rsp_ ports for one cycle, marked by rsp_valid.
// Throughput: one transaction per cycle; the pipeline never stalls, so busy is only high
// while reset is applied and up to the first clock edge after it is released.
// The depth is set by two bit-serial divider chains (16 + 13 steps).
// Reset is synchronous and active high; it clears the pipeline and loads register defaults.
module dragonfly_next_port_router (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_dest_id,
   input  logic [7:0]  req_in_port,
   input  logic [3:0]  req_in_vc,
   input  logic [9:0]  req_via_group,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_next_port,
   output logic [3:0]  rsp_out_vc,
   output logic [1:0]  rsp_status
);
   import dfr_pkg::*;

   // Configuration registers.
   logic [5:0]  hosts_ff;
   logic [6:0]  routers_ff;
   logic [5:0]  links_ff;
   logic [10:0] group_count_ff;
   logic [9:0]  own_group_ff;
   logic [5:0]  own_router_ff;
   logic        valiant_ff;
   logic        busy_ff;

   // Effective divisors: a zero register value counts as one.
   logic [5:0]  p_eff;
   logic [6:0]  a_eff;
   logic [5:0]  h_eff;
   logic [12:0] hpg;

   assign p_eff = (hosts_ff == 6'd0) ? 6'd1 : hosts_ff;
   assign a_eff = (routers_ff == 7'd0) ? 7'd1 : routers_ff;
   assign h_eff = (links_ff == 6'd0) ? 6'd1 : links_ff;
   assign hpg   = 13'(p_eff) * 13'(a_eff);

   logic accept;
   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Pipeline registers.
   a_stage_type a_ff [0:DIV_A_STEPS];
   a_stage_type a_in [0:DIV_A_STEPS];
   logic        a_valid_ff [0:DIV_A_STEPS];
   b_stage_type b_ff [0:DIV_B_STEPS];
   b_stage_type b_in [0:DIV_B_STEPS];
   logic        b_valid_ff [0:DIV_B_STEPS];

   logic        rsp_valid_ff;
   logic [7:0]  rsp_port_ff, rsp_port_in;
   logic [3:0]  rsp_vc_ff, rsp_vc_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [8:0] global_base;
   logic [3:0] vc_new;

   // Entry stage, then the first divider: one restoring step per stage,
   // destination id by hosts per group. The VC moves up when the packet
   // arrived on a global port.
   always_comb begin
      logic [13:0] trial;
      global_base = 9'(p_eff) + 9'(a_eff) - 9'd1;
      vc_new = req_in_vc;
      if ({1'b0, req_in_port} >= global_base && req_in_vc != 4'd15) begin
         vc_new = req_in_vc + 4'd1;
      end
      a_in[0].num = req_dest_id;
      a_in[0].rem = 13'd0;
      a_in[0].vc  = vc_new;
      a_in[0].via = req_via_group & GROUP_MASK;
      for (int k = 0; k < DIV_A_STEPS; k++) begin
         trial = {a_ff[k].rem, a_ff[k].num[15]};
         a_in[k + 1] = a_ff[k];
         if (trial >= {1'b0, hpg}) begin
            a_in[k + 1].rem = 13'(trial - {1'b0, hpg});
            a_in[k + 1].num = {a_ff[k].num[14:0], 1'b1};
         end else begin
            a_in[k + 1].rem = trial[12:0];
            a_in[k + 1].num = {a_ff[k].num[14:0], 1'b0};
         end
      end
   end

   // Decision stage picks the group to head for and its index with own group
   // removed; the second dividers then split the remainder by hosts per router
   // and the group index by global links.
   always_comb begin
      logic [15:0] dgrp;
      logic        diff;
      logic        valiant;
      logic [10:0] mid;
      logic [10:0] tgt;
      logic [10:0] idx;
      logic [6:0]  rtrial;
      logic [6:0]  htrial;
      dgrp = a_ff[DIV_A_STEPS].num;
      diff = dgrp != {6'd0, own_group_ff};
      valiant = valiant_ff && group_count_ff > 11'd2 && diff;
      b_in[0].status = STATUS_OK;
      b_in[0].vc     = a_ff[DIV_A_STEPS].vc;
      mid = dgrp[10:0];
      if (valiant) begin
         if ({1'b0, a_ff[DIV_A_STEPS].via} >= group_count_ff) begin
            b_in[0].status = STATUS_BAD_VIA;
         end else begin
            mid = {1'b0, a_ff[DIV_A_STEPS].via};
         end
      end
      tgt = (mid != {1'b0, own_group_ff}) ? mid : dgrp[10:0];
      idx = (tgt < {1'b0, own_group_ff}) ? tgt : tgt - 11'd1;
      if (dgrp >= {5'd0, group_count_ff}) begin
         b_in[0].mode   = MODE_DROP;
         b_in[0].status = STATUS_RANGE;
      end else if (diff) begin
         b_in[0].mode = MODE_GROUP;
      end else begin
         b_in[0].mode = MODE_LOCAL;
      end
      b_in[0].rnum = a_ff[DIV_A_STEPS].rem;
      b_in[0].rrem = 6'd0;
      b_in[0].hnum = {2'd0, idx};
      b_in[0].hrem = 6'd0;
      for (int k = 0; k < DIV_B_STEPS; k++) begin
         rtrial = {b_ff[k].rrem, b_ff[k].rnum[12]};
         htrial = {b_ff[k].hrem, b_ff[k].hnum[12]};
         b_in[k + 1] = b_ff[k];
         if (rtrial >= {1'b0, p_eff}) begin
            b_in[k + 1].rrem = 6'(rtrial - {1'b0, p_eff});
            b_in[k + 1].rnum = {b_ff[k].rnum[11:0], 1'b1};
         end else begin
            b_in[k + 1].rrem = rtrial[5:0];
            b_in[k + 1].rnum = {b_ff[k].rnum[11:0], 1'b0};
         end
         if (htrial >= {1'b0, h_eff}) begin
            b_in[k + 1].hrem = 6'(htrial - {1'b0, h_eff});
            b_in[k + 1].hnum = {b_ff[k].hnum[11:0], 1'b1};
         end else begin
            b_in[k + 1].hrem = htrial[5:0];
            b_in[k + 1].hnum = {b_ff[k].hnum[11:0], 1'b0};
         end
      end
   end

   // Final stage: turn router and gateway numbers into a port.
   always_comb begin
      b_stage_type     fin;
      logic [15:0]     rtr;
      logic [15:0]     wide;
      logic [PORT_BITS-1:0] port;
      fin  = b_ff[DIV_B_STEPS];
      rtr  = (fin.mode == MODE_GROUP) ? {3'd0, fin.hnum} : {3'd0, fin.rnum};
      wide = 16'(p_eff) + rtr;
      if (rtr > {10'd0, own_router_ff}) begin
         wide = wide - 16'd1;
      end
      case (fin.mode)
         MODE_GROUP: begin
            if (rtr == {10'd0, own_router_ff}) begin
               wide = 16'(p_eff) + 16'(a_eff) - 16'd1 + 16'(fin.hrem);
            end
         end
         MODE_LOCAL: begin
            if (rtr == {10'd0, own_router_ff}) begin
               wide = 16'(fin.rrem);
            end
         end
         default: begin
            wide = 16'd0;
         end
      endcase
      port          = PORT_BITS'(wide);
      rsp_port_in   = 8'(port);
      rsp_vc_in     = fin.vc;
      rsp_status_in = fin.status;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_A_STEPS; k++) begin
         a_ff[k] <= a_in[k];
      end
      for (int k = 0; k <= DIV_B_STEPS; k++) begin
         b_ff[k] <= b_in[k];
      end
      rsp_port_ff   <= rsp_port_in;
      rsp_vc_ff     <= rsp_vc_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         hosts_ff       <= 6'd1;
         routers_ff     <= 7'd1;
         links_ff       <= 6'd1;
         group_count_ff <= 11'd1;
         own_group_ff   <= 10'd0;
         own_router_ff  <= 6'd0;
         valiant_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k <= DIV_A_STEPS; k++) begin
            a_valid_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= DIV_B_STEPS; k++) begin
            b_valid_ff[k] <= 1'b0;
         end
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HOSTS_PER_ROUTER:  hosts_ff       <= csr_data[5:0];
               CSR_ROUTERS_PER_GROUP: routers_ff     <= csr_data[6:0];
               CSR_GLOBAL_LINKS:      links_ff       <= csr_data[5:0];
               CSR_GROUP_COUNT:       group_count_ff <= csr_data;
               CSR_OWN_GROUP:         own_group_ff   <= csr_data[9:0] & GROUP_MASK;
               CSR_OWN_ROUTER:        own_router_ff  <= csr_data[5:0];
               CSR_VALIANT_MODE:      valiant_ff     <= csr_data[0];
               default: begin
               end
            endcase
         end
         a_valid_ff[0] <= accept;
         for (int k = 0; k < DIV_A_STEPS; k++) begin
            a_valid_ff[k + 1] <= a_valid_ff[k];
         end
         b_valid_ff[0] <= a_valid_ff[DIV_A_STEPS];
         for (int k = 0; k < DIV_B_STEPS; k++) begin
            b_valid_ff[k + 1] <= b_valid_ff[k];
         end
         rsp_valid_ff <= b_valid_ff[DIV_B_STEPS];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_port = rsp_port_ff;
   assign rsp_out_vc    = rsp_vc_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
